>>> rtl/core/fbq_pkg.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer package
// Shared field widths, operation codes, sequencer states and result type.
// ----------------------------------------------------------------------------
package fbq_pkg;

   localparam int OP_W     = 2;
   localparam int FI_W     = 6;
   localparam int EI_W     = 5;
   localparam int VAL_W    = 32;
   localparam int CNT_IN_W = 6;
   localparam int CAT_W    = 6;
   localparam int FC_W     = 7;

   localparam logic [OP_W-1:0] OP_WR_DESC    = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_VALUE   = 2'd1;
   localparam logic [OP_W-1:0] OP_CATEGORIZE = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP,
      ST_SCAN,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             index_invalid;
      logic [CAT_W-1:0] category;
   } result_type;

endpackage

>>> rtl/core/fbq_ram.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module fbq_ram #(
   parameter int DW = 8,
   parameter int AW = 4
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   localparam int DEPTH = 1 << AW;

   logic [DW-1:0] mem [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/fbq_cmp.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer comparator
// Equality test for discrete features, signed less-than for bin edges.
// ----------------------------------------------------------------------------
module fbq_cmp
   import fbq_pkg::*;
(
   input  logic             discrete,
   input  logic [VAL_W-1:0] sample,
   input  logic [VAL_W-1:0] entry,
   output logic             hit
);

   always_comb begin
      if (discrete) begin
         hit = (sample == entry);
      end else begin
         hit = ($signed(sample) < $signed(entry));
      end
   end

endmodule

>>> rtl/core/fbq_seq.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer sequencer
// Clears the descriptors after reset, handles write items, walks a feature's
// table one entry per cycle and holds the result register.
// ----------------------------------------------------------------------------
module fbq_seq
   import fbq_pkg::*;
#(
   parameter int MAX_FEATURES = 64,
   parameter int MAX_ENTRIES  = 32,
   parameter int FA_W         = 6,
   parameter int EA_W         = 5,
   parameter int CNT_W        = 6
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [FI_W-1:0]       req_feature_index,
   input  logic [EI_W-1:0]       req_entry_index,
   input  logic [VAL_W-1:0]      req_value,
   input  logic                  req_discrete_flag,
   input  logic [CNT_IN_W-1:0]   req_entry_count,
   input  logic                  csr_wr_en,
   input  logic [FC_W-1:0]       csr_wr_data,
   output logic                  desc_we,
   output logic [FA_W-1:0]       desc_waddr,
   output logic [CNT_W:0]        desc_wdata,
   output logic [FA_W-1:0]       desc_raddr,
   input  logic [CNT_W:0]        desc_rdata,
   output logic                  tbl_we,
   output logic [FA_W+EA_W-1:0]  tbl_waddr,
   output logic [VAL_W-1:0]      tbl_wdata,
   output logic [FA_W+EA_W-1:0]  tbl_raddr,
   output logic                  cmp_discrete,
   output logic [VAL_W-1:0]      cmp_sample,
   input  logic                  cmp_hit,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output result_type            rsp_result
);

   state_type            state_ff, state_in;
   logic [FA_W-1:0]      clr_ff, clr_in;
   logic [FC_W-1:0]      fcount_ff;
   logic [FA_W-1:0]      feat_ff, feat_in;
   logic [VAL_W-1:0]     sample_ff, sample_in;
   logic                 invalid_ff, invalid_in;
   logic                 disc_ff, disc_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [CNT_W-1:0]     iss_ff, iss_in;
   logic                 cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]     cmp_idx_ff, cmp_idx_in;
   logic                 res_inv_ff, res_inv_in;
   logic [CNT_W-1:0]     res_cat_ff, res_cat_in;
   logic                 out_vld_ff, out_vld_in;
   result_type           out_ff, out_in;

   logic                 accept;
   logic                 fi_ok;
   logic                 ei_ok;
   logic                 issue;
   logic                 last_cmp;
   logic                 out_free;
   logic [CNT_W-1:0]     cnt_sat;
   logic [CNT_W-1:0]     cmp_next;
   logic [31:0]          res_cat_wide;

   assign accept   = req_valid && req_ready;
   assign fi_ok    = (32'(req_feature_index) < MAX_FEATURES);
   assign ei_ok    = (32'(req_entry_index) < MAX_ENTRIES);
   assign cnt_sat  = (32'(req_entry_count) > MAX_ENTRIES) ?
                     CNT_W'(MAX_ENTRIES) : CNT_W'(req_entry_count);
   assign issue    = (iss_ff < count_ff);
   assign cmp_next = cmp_idx_ff + CNT_W'(1);
   assign last_cmp = (cmp_next == count_ff);
   assign out_free = !out_vld_ff || rsp_ready;
   assign res_cat_wide = 32'(res_cat_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == FA_W'(MAX_FEATURES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept && (req_operation == OP_CATEGORIZE)) begin
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            if (invalid_ff || (desc_rdata[CNT_W-1:0] == '0)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (cmp_vld_ff && (cmp_hit || last_cmp)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      desc_we      = 1'b0;
      desc_waddr   = FA_W'(req_feature_index);
      desc_wdata   = {req_discrete_flag, cnt_sat};
      desc_raddr   = FA_W'(req_feature_index);
      tbl_we       = 1'b0;
      tbl_waddr    = {FA_W'(req_feature_index), EA_W'(req_entry_index)};
      tbl_wdata    = req_value;
      tbl_raddr    = {feat_ff, iss_ff[EA_W-1:0]};
      clr_in       = clr_ff;
      feat_in      = feat_ff;
      sample_in    = sample_ff;
      invalid_in   = invalid_ff;
      disc_in      = disc_ff;
      count_in     = count_ff;
      iss_in       = iss_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = cmp_idx_ff;
      res_inv_in   = res_inv_ff;
      res_cat_in   = res_cat_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      out_in       = out_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            desc_we    = 1'b1;
            desc_waddr = clr_ff;
            desc_wdata = '0;
            clr_in     = clr_ff + FA_W'(1);
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            desc_we   = accept && (req_operation == OP_WR_DESC) && fi_ok;
            tbl_we    = accept && (req_operation == OP_WR_VALUE) && fi_ok && ei_ok;
            feat_in    = FA_W'(req_feature_index);
            sample_in  = req_value;
            invalid_in = ({1'b0, req_feature_index} >= fcount_ff) || !fi_ok;
         end
         ST_LOOKUP: begin
            disc_in    = desc_rdata[CNT_W];
            count_in   = desc_rdata[CNT_W-1:0];
            iss_in     = '0;
            res_inv_in = invalid_ff;
            res_cat_in = '0;
         end
         ST_SCAN: begin
            iss_in     = iss_ff + CNT_W'(issue);
            cmp_vld_in = issue;
            cmp_idx_in = iss_ff;
            if (cmp_vld_ff && cmp_hit) begin
               res_cat_in = cmp_idx_ff;
            end else if (cmp_vld_ff && last_cmp) begin
               res_cat_in = disc_ff ? '0 : count_ff;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_vld_in             = 1'b1;
               out_in.index_invalid   = res_inv_ff;
               out_in.category        = res_cat_wide[CAT_W-1:0];
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_ff     <= '0;
         fcount_ff  <= '0;
         cmp_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_ff     <= clr_in;
         cmp_vld_ff <= cmp_vld_in;
         out_vld_ff <= out_vld_in;
         if (csr_wr_en) begin
            fcount_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      feat_ff    <= feat_in;
      sample_ff  <= sample_in;
      invalid_ff <= invalid_in;
      disc_ff    <= disc_in;
      count_ff   <= count_in;
      iss_ff     <= iss_in;
      cmp_idx_ff <= cmp_idx_in;
      res_inv_ff <= res_inv_in;
      res_cat_ff <= res_cat_in;
      out_ff     <= out_in;
   end

   assign cmp_discrete = disc_ff;
   assign cmp_sample   = sample_ff;
   assign rsp_valid    = out_vld_ff;
   assign rsp_result   = out_ff;

endmodule

>>> rtl/core/feature_bin_quantizer_top.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer
// Maps a Q16.16 sample of one feature to a category using per-feature
// descriptors and table values loaded by write items.
//
// Items enter on the req_ stream: tuser carries the operation, tdata the
// feature index, entry index, value, discrete flag and entry count. Write
// items give no result. A categorize item holds the block through the
// accepting cycle, a descriptor read, a scan that streams the table
// through the shared comparator, and a last step that loads the result
// register. An early match ends the scan sooner. The block takes no new
// item while it categorizes. Results leave on the rsp_ stream from an output
// register; write items are still accepted while a result waits, but a
// categorize item holds in its final cycle until the register is free. After
// reset every descriptor RAM entry is cleared in turn with req_tready low;
// csr_ writes are taken at any time. Table values are undefined until written.
// ----------------------------------------------------------------------------
module feature_bin_quantizer_top
   import fbq_pkg::*;
#(
   parameter int MAX_FEATURES = 64,
   parameter int MAX_ENTRIES  = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // feature_index[5:0], entry_index[10:6], value[42:11],
   // discrete_flag[43], entry_count[49:44], zero fill above.
   input  logic [55:0] req_tdata,
   // operation[1:0].
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // category[5:0], zero fill above.
   output logic [7:0]  rsp_tdata,
   // index_invalid[0].
   output logic        rsp_tuser,
   input  logic        csr_wr_en,
   input  logic [6:0]  csr_wr_data
);

   localparam int FA_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
   localparam int EA_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = $clog2(MAX_ENTRIES + 1);

   logic                 desc_we;
   logic [FA_W-1:0]      desc_waddr;
   logic [CNT_W:0]       desc_wdata;
   logic [FA_W-1:0]      desc_raddr;
   logic [CNT_W:0]       desc_rdata;
   logic                 tbl_we;
   logic [FA_W+EA_W-1:0] tbl_waddr;
   logic [VAL_W-1:0]     tbl_wdata;
   logic [FA_W+EA_W-1:0] tbl_raddr;
   logic [VAL_W-1:0]     tbl_rdata;
   logic                 cmp_discrete;
   logic [VAL_W-1:0]     cmp_sample;
   logic                 cmp_hit;
   result_type           rsp_result;

   fbq_seq #(
      .MAX_FEATURES (MAX_FEATURES),
      .MAX_ENTRIES  (MAX_ENTRIES),
      .FA_W         (FA_W),
      .EA_W         (EA_W),
      .CNT_W        (CNT_W)
   ) u_seq (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_operation     (req_tuser),
      .req_feature_index (req_tdata[5:0]),
      .req_entry_index   (req_tdata[10:6]),
      .req_value         (req_tdata[42:11]),
      .req_discrete_flag (req_tdata[43]),
      .req_entry_count   (req_tdata[49:44]),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data),
      .desc_we           (desc_we),
      .desc_waddr        (desc_waddr),
      .desc_wdata        (desc_wdata),
      .desc_raddr        (desc_raddr),
      .desc_rdata        (desc_rdata),
      .tbl_we            (tbl_we),
      .tbl_waddr         (tbl_waddr),
      .tbl_wdata         (tbl_wdata),
      .tbl_raddr         (tbl_raddr),
      .cmp_discrete      (cmp_discrete),
      .cmp_sample        (cmp_sample),
      .cmp_hit           (cmp_hit),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_result        (rsp_result)
   );

   fbq_ram #(
      .DW (CNT_W + 1),
      .AW (FA_W)
   ) u_desc_ram (
      .clock   (clock),
      .wr_en   (desc_we),
      .wr_addr (desc_waddr),
      .wr_data (desc_wdata),
      .rd_addr (desc_raddr),
      .rd_data (desc_rdata)
   );

   fbq_ram #(
      .DW (VAL_W),
      .AW (FA_W + EA_W)
   ) u_table_ram (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_waddr),
      .wr_data (tbl_wdata),
      .rd_addr (tbl_raddr),
      .rd_data (tbl_rdata)
   );

   fbq_cmp u_cmp (
      .discrete (cmp_discrete),
      .sample   (cmp_sample),
      .entry    (tbl_rdata),
      .hit      (cmp_hit)
   );

   assign rsp_tdata = {2'b00, rsp_result.category};
   assign rsp_tuser = rsp_result.index_invalid;

endmodule

>>> verif/fbq_tb_pkg.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer testbench package
// Holds the scoreboard: a bit-accurate copy of the descriptor and table
// state that predicts the category for every accepted categorize item and
// checks each result item against the oldest prediction.
// ----------------------------------------------------------------------------
package fbq_tb_pkg;
   import fbq_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int N_FEATURES = 64;
   localparam int N_ENTRIES  = 32;

   class fbq_scoreboard;
      logic [FC_W-1:0]  feature_limit;
      bit               is_discrete [N_FEATURES];
      int unsigned      entry_total [N_FEATURES];
      logic [VAL_W-1:0] table_word  [N_FEATURES][N_ENTRIES];
      result_type       expected_results [$];
      int unsigned      error_count;
      int unsigned      checked_count;

      function new();
         feature_limit = '0;
         error_count   = 0;
         checked_count = 0;
         foreach (is_discrete[i]) begin
            is_discrete[i] = 1'b0;
            entry_total[i] = 0;
         end
         foreach (table_word[i, j]) table_word[i][j] = '0;
      endfunction

      function void set_feature_limit(logic [FC_W-1:0] limit);
         feature_limit = limit;
      endfunction

      function logic [CAT_W-1:0] lookup_category(int fi, logic [VAL_W-1:0] sample);
         for (int i = 0; i < int'(entry_total[fi]); i++) begin
            if (is_discrete[fi]) begin
               if (table_word[fi][i] == sample) return CAT_W'(i);
            end else if ($signed(sample) < $signed(table_word[fi][i])) begin
               return CAT_W'(i);
            end
         end
         return is_discrete[fi] ? CAT_W'(0) : CAT_W'(entry_total[fi]);
      endfunction

      function void note_item(logic [OP_W-1:0] op, logic [FI_W-1:0] fi, logic [EI_W-1:0] ei,
                              logic [VAL_W-1:0] value, logic disc, logic [CNT_IN_W-1:0] cnt);
         result_type r;
         case (op)
            OP_WR_DESC: begin
               is_discrete[fi] = disc;
               entry_total[fi] = (int'(cnt) > N_ENTRIES) ? N_ENTRIES : int'(cnt);
            end
            OP_WR_VALUE: begin
               table_word[fi][ei] = value;
            end
            OP_CATEGORIZE: begin
               if ({1'b0, fi} >= feature_limit) begin
                  r.category      = '0;
                  r.index_invalid = 1'b1;
               end else begin
                  r.category      = lookup_category(int'(fi), value);
                  r.index_invalid = 1'b0;
               end
               expected_results.insert(expected_results.size(), r);
            end
            default: begin
            end
         endcase
      endfunction

      task report(string what);
         $display("MISMATCH at %0t ns: %s", $time, what);
         error_count++;
      endtask

      task check_result(logic [7:0] data, logic invalid_flag);
         result_type want;
         if (expected_results.size() == 0) begin
            report($sformatf("result item (category %0d, invalid %0b) with none pending",
                             data, invalid_flag));
            return;
         end
         want = expected_results.pop_front();
         checked_count++;
         if (data !== {2'b00, want.category})
            report($sformatf("category %0d, expected %0d", data, want.category));
         if (invalid_flag !== want.index_invalid)
            report($sformatf("index_invalid %0b, expected %0b", invalid_flag,
                             want.index_invalid));
      endtask

      function int unsigned pending();
         return expected_results.size();
      endfunction
   endclass

endpackage

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// Feature bin quantizer testbench
// Drives descriptor writes, table writes and categorize items through the
// request stream under several feature counts, with random idle bursts on
// both streams, and checks every result item against the scoreboard.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import fbq_pkg::*;
   import fbq_tb_pkg::*;

   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 40;
   localparam int RANDOM_ITEMS  = 1500;
   localparam int N_PHASES      = 8;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_tvalid  = 1'b0;
   logic [55:0] req_tdata   = '0;
   logic [1:0]  req_tuser   = '0;
   logic        rsp_tready  = 1'b0;
   logic        csr_wr_en   = 1'b0;
   logic [6:0]  csr_wr_data = '0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [7:0]  rsp_tdata;
   logic        rsp_tuser;

   fbq_scoreboard    sb;
   int unsigned      gen_count   [N_FEATURES];
   logic [N_ENTRIES-1:0] gen_written [N_FEATURES];
   logic [VAL_W-1:0] gen_value   [N_FEATURES][N_ENTRIES];
   logic [FC_W-1:0]  gen_limit;
   bit               idle_on;
   int unsigned      req_gap_pct;
   int unsigned      rsp_stall_pct;
   int unsigned      stall_left;
   int unsigned      items_sent;
   int unsigned      phases_run;
   int unsigned      cycle_count;

   feature_bin_quantizer_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results pending", cycle_count,
                  sb.pending());
         $display("== FAIL ==");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < rsp_stall_pct) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_item(input logic [OP_W-1:0] op, input logic [FI_W-1:0] fi,
                            input logic [EI_W-1:0] ei, input logic [VAL_W-1:0] value,
                            input logic disc, input logic [CNT_IN_W-1:0] cnt);
      if (idle_on && $urandom_range(0, 99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b000000, cnt, disc, value, ei, fi};
      do @(posedge clock); while (!req_tready);
      sb.note_item(op, fi, ei, value, disc, cnt);
      if (op == OP_WR_DESC) begin
         gen_count[fi] = (int'(cnt) > N_ENTRIES) ? N_ENTRIES : int'(cnt);
      end else if (op == OP_WR_VALUE) begin
         gen_written[fi][ei] = 1'b1;
         gen_value[fi][ei]   = value;
      end
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic categorize(input int fi, input logic [VAL_W-1:0] sample);
      send_item(OP_CATEGORIZE, FI_W'(fi), EI_W'($urandom), sample,
                1'($urandom_range(0, 1)), CNT_IN_W'($urandom));
   endtask

   task automatic write_value(input int fi, input int ei, input logic [VAL_W-1:0] value);
      send_item(OP_WR_VALUE, FI_W'(fi), EI_W'(ei), value, 1'($urandom_range(0, 1)),
                CNT_IN_W'($urandom));
   endtask

   task automatic write_descriptor(input int fi, input logic disc, input int cnt);
      send_item(OP_WR_DESC, FI_W'(fi), EI_W'($urandom), VAL_W'($urandom), disc,
                CNT_IN_W'(cnt));
   endtask

   function automatic bit feature_ready(int fi);
      logic [N_ENTRIES-1:0] need;
      need = (gen_count[fi] >= N_ENTRIES) ? '1 : ((N_ENTRIES'(1) << gen_count[fi]) - 1'b1);
      return (gen_written[fi] & need) == need;
   endfunction

   function automatic int pick_feature();
      int top;
      top = (int'(gen_limit) > N_FEATURES) ? N_FEATURES : int'(gen_limit);
      if (top > 0 && $urandom_range(0, 3) != 0) return $urandom_range(0, top - 1);
      return $urandom_range(0, N_FEATURES - 1);
   endfunction

   function automatic logic [VAL_W-1:0] pick_sample(int fi);
      logic [VAL_W-1:0] base;
      base = (gen_count[fi] > 0) ? gen_value[fi][$urandom_range(0, gen_count[fi] - 1)]
                                 : VAL_W'($urandom);
      case ($urandom_range(0, 6))
         0, 1:    return base;
         2:       return base + 1'b1;
         3:       return base - 1'b1;
         4:       return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
         5:       return VAL_W'($urandom_range(0, 15)) - 32'd8;
         default: return VAL_W'($urandom);
      endcase
   endfunction

   task automatic program_feature(input int fi);
      logic             disc;
      int               cnt_field;
      int               n;
      int               step;
      logic [VAL_W-1:0] level;
      logic [VAL_W-1:0] value;
      disc = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0:       cnt_field = $urandom_range(33, 63);
         1:       cnt_field = 32;
         2:       cnt_field = $urandom_range(13, 31);
         default: cnt_field = $urandom_range(0, 12);
      endcase
      n     = (cnt_field > N_ENTRIES) ? N_ENTRIES : cnt_field;
      step  = 1 << $urandom_range(0, 26);
      level = $urandom_range(0, 1) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 63)) - 32'd32;
      write_descriptor(fi, disc, cnt_field);
      for (int i = 0; i < n; i++) begin
         if (disc) begin
            value = level + VAL_W'($urandom_range(0, 7));
         end else begin
            level = level + VAL_W'($urandom_range(0, step));
            value = level;
         end
         write_value(fi, i, value);
      end
      repeat ($urandom_range(2, 8)) categorize(fi, pick_sample(fi));
   endtask

   task automatic random_item();
      int r;
      int fi;
      int missing;
      r       = $urandom_range(0, 99);
      fi      = pick_feature();
      missing = -1;
      if (r < 55) begin
         program_feature(fi);
      end else if (r < 80) begin
         if (fi >= int'(gen_limit) || feature_ready(fi)) begin
            categorize(fi, pick_sample(fi));
         end else begin
            for (int i = N_ENTRIES - 1; i >= 0; i--) if (!gen_written[fi][i]) missing = i;
            write_value(fi, missing, VAL_W'($urandom));
         end
      end else if (r < 88) begin
         write_value(fi, $urandom_range(0, N_ENTRIES - 1), VAL_W'($urandom));
      end else if (r < 94) begin
         write_descriptor(fi, 1'($urandom_range(0, 1)), $urandom_range(0, 63));
      end else begin
         send_item(OP_UNUSED, FI_W'($urandom), EI_W'($urandom), VAL_W'($urandom),
                   1'($urandom_range(0, 1)), CNT_IN_W'($urandom));
      end
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic drain();
      wait_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_limit(input int limit);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= FC_W'(limit);
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_feature_limit(FC_W'(limit));
      gen_limit = FC_W'(limit);
   endtask

   task automatic directed_items();
      write_descriptor(0, 1'b0, 3);
      write_value(0, 0, 32'h8000_0000);
      write_value(0, 1, 32'h0000_0000);
      write_value(0, 2, 32'h7FFF_FFFF);
      categorize(0, 32'h8000_0000);
      categorize(0, 32'h7FFF_FFFF);
      categorize(0, 32'hFFFF_FFFF);
      categorize(0, 32'h0000_0000);
      write_descriptor(63, 1'b1, 2);
      write_value(63, 0, 32'h0005_0000);
      write_value(63, 1, 32'h0007_0000);
      categorize(63, 32'h0007_0000);
      categorize(63, 32'h0005_0000);
      categorize(63, 32'h0009_0000);
      write_value(63, 31, 32'h7FFF_FFFF);
      // The unused operation must leave feature 0 untouched.
      send_item(OP_UNUSED, 6'd0, 5'd31, 32'hFFFF_FFFF, 1'b1, 6'd0);
      categorize(0, 32'h0000_0000);
      write_descriptor(5, 1'b1, 0);
      categorize(5, 32'h0000_0000);
      categorize(6, 32'h1234_5678);
   endtask

   initial begin
      int plan [N_PHASES];
      int unsigned budget;
      plan = '{64, 0, 127, 1, 63, 65, 0, 64};
      plan[6] = $urandom_range(0, 127);
      sb = new();
      foreach (gen_count[i]) begin
         gen_count[i]   = 0;
         gen_written[i] = '0;
      end
      foreach (gen_value[i, j]) gen_value[i][j] = '0;
      gen_limit     = '0;
      idle_on       = 1'b1;
      req_gap_pct   = 20;
      rsp_stall_pct = 20;
      stall_left    = 0;
      items_sent    = 0;
      phases_run    = 0;
      cycle_count   = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      for (int p = 0; p < N_PHASES; p++) begin
         if (p > 0) drain();
         set_limit(plan[p]);
         if (p == 0) directed_items();
         if (p == N_PHASES - 1) begin
            idle_on       = 1'b0;
            req_gap_pct   = 0;
            rsp_stall_pct = 0;
         end
         budget = items_sent + RANDOM_ITEMS / N_PHASES;
         while (items_sent < budget) begin
            if (idle_on && $urandom_range(0, 15) == 0) begin
               req_gap_pct   = $urandom_range(0, 2) * 15;
               rsp_stall_pct = $urandom_range(0, 2) * 15;
            end
            if ($urandom_range(0, 49) == 0) wait_results();
            random_item();
         end
         phases_run++;
      end
      drain();
      $display("Run covered %0d items over %0d feature-count settings (0, 1, 63 to 65, 127).",
               items_sent, phases_run);
      $display("Checked %0d categorize results; %0d mismatches.", sb.checked_count,
               sb.error_count);
      if (sb.error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/core/fbq_pkg.sv
rtl/core/fbq_ram.sv
rtl/core/fbq_cmp.sv
rtl/core/fbq_seq.sv
rtl/core/feature_bin_quantizer_top.sv
verif/fbq_tb_pkg.sv
verif/tb_top.sv
